// File: design/rpoc_pkg.sv
// Package for the range paint ones counter.
// Holds the field widths, word geometry and the structs passed between the
// sequencer, the word memory and the bit unit. No dependencies.
`timescale 1ns / 1ps

package rpoc_pkg;

    // Width of a one-based position and of the ones total.
    localparam int POS_W = 11;
    // Largest position an 11-bit range can reach.
    localparam int MAX_ROW = 2047;
    // Storage word geometry: the row is kept as 32-bit words.
    localparam int WORD_W = 32;
    localparam int BIT_W = 5;
    // Word index wide enough for MAX_ROW positions.
    localparam int WIDX_W = 6;
    // Popcount of one word: 0..32.
    localparam int FLIP_W = 6;

    typedef logic [WORD_W-1:0] word_t;

    // Request from the sequencer to the word memory.
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [WIDX_W-1:0] addr;
        word_t             wdata;
    } mem_req_t;

    // Operation handed to the bit unit for one word.
    typedef struct packed {
        word_t            old_word;
        logic [BIT_W-1:0] lo_bit;
        logic [BIT_W-1:0] hi_bit;
        logic             paint;
    } bit_op_t;

    // Result of the bit unit: the painted word and how many bits changed.
    typedef struct packed {
        word_t             new_word;
        logic [FLIP_W-1:0] flips;
    } bit_res_t;

endpackage

// File: design/rpoc_ifs.sv
// Handshake interfaces for the range paint ones counter: the paint request
// channel and the ones total channel. Depends on rpoc_pkg.
`timescale 1ns / 1ps

interface rpoc_paint_if;
    logic                      valid;
    logic                      ready;
    logic [rpoc_pkg::POS_W-1:0] range_start;
    logic [rpoc_pkg::POS_W-1:0] range_end;
    logic                      paint_one;

    modport source (output valid, range_start, range_end, paint_one, input ready);
    modport sink (input valid, range_start, range_end, paint_one, output ready);
endinterface

interface rpoc_total_if;
    logic                      valid;
    logic                      ready;
    logic [rpoc_pkg::POS_W-1:0] ones_total;

    modport source (output valid, ones_total, input ready);
    modport sink (input valid, ones_total, output ready);
endinterface

// File: design/rpoc_word_mem.sv
// Word memory holding the row of bits, with one valid bit per word so that
// reset clears the row at once. Depends on rpoc_pkg.
`timescale 1ns / 1ps

module rpoc_word_mem #(
    parameter int WORDS = 32,
    parameter int AW = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rpoc_pkg::mem_req_t  req,
    output rpoc_pkg::word_t     rd_word
);

    rpoc_pkg::word_t mem [WORDS];
    logic [WORDS-1:0] vld_reg;
    rpoc_pkg::word_t  rd_word_reg;
    logic             rd_vld_reg;
    logic [AW-1:0]    idx;

    assign idx = req.addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[idx] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[idx] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[idx];
            end
        end
    end

    // A word never written since reset reads as all zero.
    assign rd_word = rd_vld_reg ? rd_word_reg : '0;

endmodule

// File: design/rpoc_bit_unit.sv
// Shared bit unit: paints a bit range of one word and counts the bits that
// changed. Depends on rpoc_pkg.
`timescale 1ns / 1ps

module rpoc_bit_unit (
    input  rpoc_pkg::bit_op_t  op,
    output rpoc_pkg::bit_res_t res
);

    rpoc_pkg::word_t mask;
    rpoc_pkg::word_t changed;

    always_comb
    begin
        mask = ({rpoc_pkg::WORD_W{1'b1}} << op.lo_bit)
             & ({rpoc_pkg::WORD_W{1'b1}} >> (5'(rpoc_pkg::WORD_W - 1) - op.hi_bit));
        if (op.paint)
        begin
            changed      = mask & ~op.old_word;
            res.new_word = op.old_word | mask;
        end
        else
        begin
            changed      = mask & op.old_word;
            res.new_word = op.old_word & ~mask;
        end
        res.flips = rpoc_pkg::FLIP_W'($countones(changed));
    end

endmodule

// File: design/rpoc_ctrl.sv
// Sequencer for the range paint ones counter: clips the range, walks the
// covered words through read and modify steps and keeps the running total.
// Depends on rpoc_pkg and the interfaces in rpoc_ifs.
`timescale 1ns / 1ps

module rpoc_ctrl #(
    parameter int ROW_BITS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    rpoc_paint_if.sink         paint_ch,
    rpoc_total_if.source       total_ch,
    output rpoc_pkg::mem_req_t mem_req,
    input  rpoc_pkg::word_t    mem_rd_word,
    output rpoc_pkg::bit_op_t  bit_op,
    input  rpoc_pkg::bit_res_t bit_res
);

    localparam logic [rpoc_pkg::POS_W-1:0] ROW_LAST = rpoc_pkg::POS_W'(ROW_BITS);

    typedef enum logic [1:0] {IDLE, RD, MOD, DONE} state_t;

    state_t                          state_reg, state_next;
    logic [rpoc_pkg::WIDX_W-1:0]     w_reg, w_next;
    logic [rpoc_pkg::WIDX_W-1:0]     w_first_reg, w_first_next;
    logic [rpoc_pkg::WIDX_W-1:0]     w_last_reg, w_last_next;
    logic [rpoc_pkg::BIT_W-1:0]      lo_bit_reg, lo_bit_next;
    logic [rpoc_pkg::BIT_W-1:0]      hi_bit_reg, hi_bit_next;
    logic                            paint_reg, paint_next;
    logic [rpoc_pkg::POS_W-1:0]      total_reg, total_next;
    logic                            out_valid_reg, out_valid_next;
    logic [rpoc_pkg::POS_W-1:0]      out_total_reg, out_total_next;

    logic [rpoc_pkg::POS_W-1:0]      lo_c, hi_c, p0, p1;
    logic                            accept;

    assign accept = paint_ch.valid && paint_ch.ready;
    assign paint_ch.ready = (state_reg == IDLE);
    assign total_ch.valid = out_valid_reg;
    assign total_ch.ones_total = out_total_reg;

    // Clip the range to the stored row; convert to zero-based positions.
    always_comb
    begin
        lo_c = (paint_ch.range_start == '0) ? rpoc_pkg::POS_W'(1) : paint_ch.range_start;
        hi_c = (paint_ch.range_end > ROW_LAST) ? ROW_LAST : paint_ch.range_end;
        p0   = lo_c - rpoc_pkg::POS_W'(1);
        p1   = hi_c - rpoc_pkg::POS_W'(1);
    end

    always_comb
    begin
        mem_req.rd_en = (state_reg == RD);
        mem_req.wr_en = (state_reg == MOD);
        mem_req.addr  = w_reg;
        mem_req.wdata = bit_res.new_word;

        bit_op.old_word = mem_rd_word;
        bit_op.lo_bit   = (w_reg == w_first_reg) ? lo_bit_reg : '0;
        bit_op.hi_bit   = (w_reg == w_last_reg) ? hi_bit_reg : '1;
        bit_op.paint    = paint_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        w_first_next   = w_first_reg;
        w_last_next    = w_last_reg;
        lo_bit_next    = lo_bit_reg;
        hi_bit_next    = hi_bit_reg;
        paint_next     = paint_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !total_ch.ready;
        out_total_next = out_total_reg;

        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if (lo_c > hi_c)
                    begin
                        state_next = DONE;
                    end
                    else
                    begin
                        w_next       = p0[rpoc_pkg::POS_W-1:rpoc_pkg::BIT_W];
                        w_first_next = p0[rpoc_pkg::POS_W-1:rpoc_pkg::BIT_W];
                        w_last_next  = p1[rpoc_pkg::POS_W-1:rpoc_pkg::BIT_W];
                        lo_bit_next  = p0[rpoc_pkg::BIT_W-1:0];
                        hi_bit_next  = p1[rpoc_pkg::BIT_W-1:0];
                        paint_next   = paint_ch.paint_one;
                        state_next   = RD;
                    end
                end
            end
            RD:
            begin
                state_next = MOD;
            end
            MOD:
            begin
                if (paint_reg)
                begin
                    total_next = total_reg + rpoc_pkg::POS_W'(bit_res.flips);
                end
                else
                begin
                    total_next = total_reg - rpoc_pkg::POS_W'(bit_res.flips);
                end
                if (w_reg == w_last_reg)
                begin
                    state_next = DONE;
                end
                else
                begin
                    w_next     = w_reg + rpoc_pkg::WIDX_W'(1);
                    state_next = RD;
                end
            end
            DONE:
            begin
                if (!out_valid_reg || total_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = total_reg;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            w_reg         <= '0;
            w_first_reg   <= '0;
            w_last_reg    <= '0;
            lo_bit_reg    <= '0;
            hi_bit_reg    <= '0;
            paint_reg     <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            w_first_reg   <= w_first_next;
            w_last_reg    <= w_last_next;
            lo_bit_reg    <= lo_bit_next;
            hi_bit_reg    <= hi_bit_next;
            paint_reg     <= paint_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            out_total_reg <= out_total_next;
        end
    end

    // An accepted beat always starts work; the block is busy next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != IDLE))
        else $error("sequencer idle right after an accepted beat");

    // The total can never exceed the number of stored positions.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= ROW_LAST)
        else $error("ones total beyond row length");

    // The word walk stays inside the clipped range.
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RD || state_reg == MOD) |->
            (w_reg >= w_first_reg && w_reg <= w_last_reg))
        else $error("word index outside painted range");

    // Every write-back follows the read of the same word.
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> ($past(mem_req.rd_en) && $past(mem_req.addr) == mem_req.addr))
        else $error("write-back without matching read");

endmodule

// File: design/range_paint_ones_counter_top.sv
// Top level of the range paint ones counter: sequencer, word memory and the
// shared bit unit. Depends on rpoc_pkg, rpoc_ifs and the rpoc_* modules.
`timescale 1ns / 1ps

// Channel    Role    Beat payload
// paint_ch   sink    range_start, range_end (one-based, inclusive), paint_one
// total_ch   source  ones_total, number of ones in the row after the paint
//
// A beat that covers words w0..w1 of the 32-bit storage takes one read step and
// one modify/write-back step per word through the single memory port, plus
// accept and finish steps; an empty or out-of-row range goes straight from
// accept to finish.
// Reset clears the row at once through per-word valid bits; no sweep is needed.
// A result waiting on total_ch does not block the next paint; only the finish
// step of that next paint waits for the output register to free up.

module range_paint_ones_counter_top #(
    parameter int SIZE = 1024
) (
    input logic          clk,
    input logic          rst_n,
    rpoc_paint_if.sink   paint_ch,
    rpoc_total_if.source total_ch
);

    // Positions above 2047 can never be painted by an 11-bit range, so the
    // stored row stops there; the rest of the row stays zero for good.
    localparam int ROW_BITS = (SIZE < rpoc_pkg::MAX_ROW) ? SIZE : rpoc_pkg::MAX_ROW;
    localparam int WORDS = (ROW_BITS + rpoc_pkg::WORD_W - 1) / rpoc_pkg::WORD_W;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    rpoc_pkg::mem_req_t mem_req;
    rpoc_pkg::word_t    mem_rd_word;
    rpoc_pkg::bit_op_t  bit_op;
    rpoc_pkg::bit_res_t bit_res;

    // Sequencer: clips the range and walks the touched words.
    rpoc_ctrl #(
        .ROW_BITS (ROW_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .paint_ch    (paint_ch),
        .total_ch    (total_ch),
        .mem_req     (mem_req),
        .mem_rd_word (mem_rd_word),
        .bit_op      (bit_op),
        .bit_res     (bit_res)
    );

    // Row storage, one word per address, registered read.
    rpoc_word_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_word (mem_rd_word)
    );

    // Shared unit that paints one word and counts the changed bits.
    rpoc_bit_unit u_bits (
        .op  (bit_op),
        .res (bit_res)
    );

endmodule

// File: test/range_paint_ones_counter_top_tb.sv
`timescale 1ns / 1ps
// Testbench for range_paint_ones_counter_top. It paints ranges of the row and
// checks each ones total against a bit-per-position model of the row.
// Depends on rpoc_pkg, rpoc_ifs and the design sources.

module range_paint_ones_counter_top_tb;

    // The row length the block is built with.
    localparam int ROW_LEN = 1024;
    // Long enough for a full-row paint still in flight to finish.
    localparam int DRAIN_CYCLES = 100;
    // Random paint beats per idling phase; four phases plus the edge cases
    // come to roughly 1950 beats.
    localparam int PHASE_BEATS = 482;

    logic clk;
    logic rst_n;

    rpoc_paint_if paint_ch();
    rpoc_total_if total_ch();

    range_paint_ones_counter_top #(
        .SIZE(ROW_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .paint_ch(paint_ch),
        .total_ch(total_ch)
    );

    // Model of the row: one bit per one-based position plus a running count.
    bit row_bits [1:ROW_LEN];
    int unsigned ones_in_row = 0;

    // Ones totals the block still owes, oldest first.
    logic [rpoc_pkg::POS_W-1:0] expected_totals [$];

    int unsigned mismatch_count = 0;

    // Chance, in percent, that the sender idles or the receiver stalls in a cycle.
    int unsigned paint_idle_pct = 0;
    int unsigned total_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one paint to the model row and returns the new ones total.
    // An empty range (start above end) leaves the row alone. Otherwise the
    // range is clipped to the row: a start of zero acts as one and an end
    // past the row acts as its last position.
    function automatic logic [rpoc_pkg::POS_W-1:0] paint_and_count(
        input logic [rpoc_pkg::POS_W-1:0] first_pos,
        input logic [rpoc_pkg::POS_W-1:0] last_pos,
        input logic                       value
    );
        int lo;
        int hi;
        lo = (first_pos == '0) ? 1 : int'(first_pos);
        hi = (int'(last_pos) > ROW_LEN) ? ROW_LEN : int'(last_pos);
        if (first_pos <= last_pos)
        begin
            for (int pos = lo; pos <= hi; pos++)
            begin
                if (row_bits[pos] != value)
                begin
                    row_bits[pos] = value;
                    if (value)
                        ones_in_row++;
                    else
                        ones_in_row--;
                end
            end
        end
        return ones_in_row[rpoc_pkg::POS_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    // Sends one paint beat. Valid is only lowered when the sender idles, so a
    // beat that follows at once keeps valid high with a single assignment.
    // The expected total is worked out at the edge where the beat is taken.
    task automatic send_paint(
        input logic [rpoc_pkg::POS_W-1:0] first_pos,
        input logic [rpoc_pkg::POS_W-1:0] last_pos,
        input logic                       value
    );
        while ($urandom_range(0, 99) < paint_idle_pct)
        begin
            paint_ch.valid <= 1'b0;
            @(posedge clk);
        end
        paint_ch.valid       <= 1'b1;
        paint_ch.range_start <= first_pos;
        paint_ch.range_end   <= last_pos;
        paint_ch.paint_one   <= value;
        @(posedge clk);
        while (!paint_ch.ready)
            @(posedge clk);
        expected_totals.push_back(paint_and_count(first_pos, last_pos, value));
    endtask

    // Most random beats are short ranges inside the row, which keeps the block
    // fast and the row patchy. The rest are long ranges, raw 11-bit values,
    // empty ranges and ranges that hang over either end of the row.
    task automatic run_random_paints(input int unsigned beats);
        int unsigned kind;
        int unsigned pos_a;
        int unsigned pos_b;
        logic        value;
        for (int unsigned n = 0; n < beats; n++)
        begin
            kind  = $urandom_range(0, 99);
            value = 1'($urandom_range(0, 1));
            if (kind < 70)
            begin
                pos_a = $urandom_range(1, ROW_LEN);
                pos_b = pos_a + $urandom_range(0, 39);
            end
            else if (kind < 80)
            begin
                pos_a = $urandom_range(1, ROW_LEN);
                pos_b = $urandom_range(1, ROW_LEN);
                if (pos_a > pos_b)
                begin
                    pos_a = pos_a ^ pos_b;
                    pos_b = pos_a ^ pos_b;
                    pos_a = pos_a ^ pos_b;
                end
            end
            else if (kind < 90)
            begin
                pos_a = $urandom_range(0, rpoc_pkg::MAX_ROW);
                pos_b = $urandom_range(0, rpoc_pkg::MAX_ROW);
            end
            else if (kind < 95)
            begin
                pos_a = $urandom_range(1, rpoc_pkg::MAX_ROW);
                pos_b = $urandom_range(0, pos_a - 1);
            end
            else if (kind < 97)
            begin
                pos_a = 0;
                pos_b = $urandom_range(0, ROW_LEN);
            end
            else
            begin
                pos_a = $urandom_range(1, ROW_LEN);
                pos_b = $urandom_range(ROW_LEN + 1, rpoc_pkg::MAX_ROW);
            end
            send_paint(pos_a[rpoc_pkg::POS_W-1:0], pos_b[rpoc_pkg::POS_W-1:0], value);
        end
    endtask

    // Edge cases: the full row, the first and last positions, empty ranges,
    // clipping at both ends, ranges wholly past the row and word boundaries.
    task automatic test_row_edges();
        paint_idle_pct  = 0;
        total_stall_pct = 0;
        send_paint(11'd1, 11'd1024, 1'b1);
        send_paint(11'd1, 11'd1, 1'b0);
        send_paint(11'd1024, 11'd1024, 1'b0);
        send_paint(11'd5, 11'd3, 1'b0);
        send_paint(11'd0, 11'd2047, 1'b0);
        send_paint(11'd0, 11'd0, 1'b1);
        send_paint(11'd1025, 11'd2047, 1'b1);
        send_paint(11'd2047, 11'd2047, 1'b1);
        send_paint(11'd2047, 11'd0, 1'b1);
        send_paint(11'd1, 11'd1, 1'b1);
        send_paint(11'd1024, 11'd1024, 1'b1);
        send_paint(11'd32, 11'd33, 1'b1);
        send_paint(11'd31, 11'd64, 1'b1);
        send_paint(11'd65, 11'd96, 1'b1);
        send_paint(11'd0, 11'd5, 1'b1);
        send_paint(11'd1000, 11'd2047, 1'b1);
        send_paint(11'd40, 11'd50, 1'b0);
        send_paint(11'd2, 11'd1023, 1'b0);
        send_paint(11'd512, 11'd513, 1'b1);
        send_paint(11'd682, 11'd1365, 1'b1);
        send_paint(11'd1, 11'd1024, 1'b0);
        send_paint(11'd1, 11'd1024, 1'b1);
    endtask

    task automatic test_paints_no_idle();
        paint_idle_pct  = 0;
        total_stall_pct = 0;
        run_random_paints(PHASE_BEATS);
    endtask

    task automatic test_paints_sender_idle();
        paint_idle_pct  = 58;
        total_stall_pct = 0;
        run_random_paints(PHASE_BEATS);
    endtask

    task automatic test_paints_receiver_stall();
        paint_idle_pct  = 0;
        total_stall_pct = 58;
        run_random_paints(PHASE_BEATS);
    endtask

    task automatic test_paints_both_idle();
        paint_idle_pct  = 27;
        total_stall_pct = 27;
        run_random_paints(PHASE_BEATS);
    endtask

    // Result side: takes each ones total beat, compares it with the oldest
    // expectation, then decides ready for the next cycle.
    initial
    begin
        total_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && total_ch.valid && total_ch.ready)
            begin
                if (expected_totals.size() == 0)
                begin
                    report_mismatch($sformatf("ones_total %0d with no paint outstanding",
                                              total_ch.ones_total));
                end
                else if (total_ch.ones_total !== expected_totals[0])
                begin
                    report_mismatch($sformatf("ones_total expected %0d, got %0d",
                                              expected_totals[0], total_ch.ones_total));
                    void'(expected_totals.pop_front());
                end
                else
                begin
                    void'(expected_totals.pop_front());
                end
            end
            total_ch.ready <= ($urandom_range(0, 99) >= total_stall_pct);
        end
    end

    // Runs the tests in turn, lets the last totals drain and gives the verdict.
    initial
    begin
        rst_n                <= 1'b0;
        paint_ch.valid       <= 1'b0;
        paint_ch.range_start <= '0;
        paint_ch.range_end   <= '0;
        paint_ch.paint_one   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_row_edges();
        test_paints_no_idle();
        test_paints_sender_idle();
        test_paints_receiver_stall();
        test_paints_both_idle();

        paint_ch.valid <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("range_paint_ones_counter_top_tb OK");
        else
            $display("range_paint_ones_counter_top_tb NOT OK");
        $finish;
    end

    // A hung handshake ends the run here. A correct run needs well under a
    // fifth of this time even with every beat painting the full row.
    initial
    begin
        #20_000_000;
        $display("range_paint_ones_counter_top_tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
design/rpoc_pkg.sv
design/rpoc_ifs.sv
design/rpoc_word_mem.sv
design/rpoc_bit_unit.sv
design/rpoc_ctrl.sv
design/range_paint_ones_counter_top.sv
test/range_paint_ones_counter_top_tb.sv
